@@ hdl/pcog_pkg.sv @@
// shared types, constants and register codes for the phase current overcurrent guard
`default_nettype none

package pcog_pkg;

  localparam int CODE_W     = 12;
  localparam int CUR_W      = 16;
  localparam int PHASE_W_W  = 18;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam int DEFAULT_WINDOW = 8;

  // pipeline stage positions
  localparam int ST_DIFF    = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_RAW     = 2;
  localparam int ST_SUM     = 3;
  localparam int ST_QMUL    = 4;
  localparam int ST_FILT    = 5;
  localparam int ST_WPH     = 6;
  localparam int ST_CMP     = 7;
  localparam int ST_OUT     = 8;
  localparam int NUM_STAGES = 9;

  localparam logic signed [CUR_W-1:0] CUR_MAX = 16'sh7FFF;
  localparam logic signed [CUR_W-1:0] CUR_MIN = 16'sh8000;
  localparam logic [CNT_W-1:0]        CNT_MAX = 8'hFF;

  localparam logic [CODE_W-1:0] RST_ADC_MIDPOINT     = 12'd2048;
  localparam logic [15:0]       RST_CURRENT_GAIN     = 16'd256;
  localparam logic [15:0]       RST_CORRECTION       = 16'd0;
  localparam logic [15:0]       RST_THRESHOLD        = 16'hFFFF;
  localparam logic [CNT_W-1:0]  RST_INSTANT_LIMIT    = 8'd1;
  localparam logic [CNT_W-1:0]  RST_CONTINUOUS_LIMIT = 8'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ADC_MIDPOINT           = 4'd0,
    REG_CURRENT_GAIN           = 4'd1,
    REG_CORRECTION_U           = 4'd2,
    REG_CORRECTION_V           = 4'd3,
    REG_INSTANT_THRESHOLD      = 4'd4,
    REG_CONTINUOUS_THRESHOLD   = 4'd5,
    REG_INSTANT_COUNT_LIMIT    = 4'd6,
    REG_CONTINUOUS_COUNT_LIMIT = 4'd7
  } cfg_reg_t;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // per-stage load strobes and the opcode of the item held in each stage
  typedef struct packed {
    logic [NUM_STAGES-1:0] ld;
    logic [NUM_STAGES-1:0] clr;
  } pipe_ctl_t;

endpackage

`default_nettype wire

@@ hdl/phase_current_overcurrent_guard.sv @@
// Phase current overcurrent guard. Each item carries either a U/V pair of 12-bit
// ADC codes or a clear command. The two phases run in identical lanes (scale to
// Q8.8, ring of WINDOW samples, running sum, floor average by reciprocal multiply)
// and a merge stage rebuilds W, checks raw and filtered peak magnitudes against
// their thresholds and runs the trip counters and latch. The block takes one item
// per clock and carries each one through the nine register stages of the lane
// and merge pipeline; a stalled result only holds back items once every stage
// is full. The rings need no clearing pass after reset: each slot has a valid
// bit and reads as zero until first written. Configuration writes are always
// ready and should only be made while no item is in flight; writes to indexes
// above 7 are dropped.
`default_nettype none

module phase_current_overcurrent_guard #(
  parameter int WINDOW = pcog_pkg::DEFAULT_WINDOW
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 sample_valid,
  output logic                                      sample_stall,
  input  wire logic                                 opcode,
  input  wire logic [pcog_pkg::CODE_W-1:0]          adc_code_u,
  input  wire logic [pcog_pkg::CODE_W-1:0]          adc_code_v,
  output logic                                      result_valid,
  input  wire logic                                 result_stall,
  output logic signed [pcog_pkg::CUR_W-1:0]         filtered_u,
  output logic signed [pcog_pkg::CUR_W-1:0]         filtered_v,
  output logic signed [pcog_pkg::PHASE_W_W-1:0]     filtered_w,
  output logic                                      trip_latched,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pcog_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [pcog_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [pcog_pkg::CODE_W-1:0] adc_midpoint;
  logic [15:0]                 current_gain;
  logic signed [15:0]          correction_u;
  logic signed [15:0]          correction_v;
  logic [15:0]                 instant_threshold;
  logic [15:0]                 continuous_threshold;
  logic [pcog_pkg::CNT_W-1:0]  instant_count_limit;
  logic [pcog_pkg::CNT_W-1:0]  continuous_count_limit;

  pcog_pkg::pipe_ctl_t         ctl;
  logic [SLOT_W-1:0]           rd_slot;
  logic [SLOT_W-1:0]           wr_slot;
  logic signed [pcog_pkg::CUR_W-1:0] raw_u;
  logic signed [pcog_pkg::CUR_W-1:0] raw_v;
  logic signed [pcog_pkg::CUR_W-1:0] filt_u;
  logic signed [pcog_pkg::CUR_W-1:0] filt_v;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      adc_midpoint           <= pcog_pkg::RST_ADC_MIDPOINT;
      current_gain           <= pcog_pkg::RST_CURRENT_GAIN;
      correction_u           <= pcog_pkg::RST_CORRECTION;
      correction_v           <= pcog_pkg::RST_CORRECTION;
      instant_threshold      <= pcog_pkg::RST_THRESHOLD;
      continuous_threshold   <= pcog_pkg::RST_THRESHOLD;
      instant_count_limit    <= pcog_pkg::RST_INSTANT_LIMIT;
      continuous_count_limit <= pcog_pkg::RST_CONTINUOUS_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pcog_pkg::REG_ADC_MIDPOINT:           adc_midpoint <= cfg_data[pcog_pkg::CODE_W-1:0];
        pcog_pkg::REG_CURRENT_GAIN:           current_gain <= cfg_data;
        pcog_pkg::REG_CORRECTION_U:           correction_u <= cfg_data;
        pcog_pkg::REG_CORRECTION_V:           correction_v <= cfg_data;
        pcog_pkg::REG_INSTANT_THRESHOLD:      instant_threshold <= cfg_data;
        pcog_pkg::REG_CONTINUOUS_THRESHOLD:   continuous_threshold <= cfg_data;
        pcog_pkg::REG_INSTANT_COUNT_LIMIT:    instant_count_limit <= cfg_data[pcog_pkg::CNT_W-1:0];
        pcog_pkg::REG_CONTINUOUS_COUNT_LIMIT: continuous_count_limit <= cfg_data[pcog_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pcog_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .opcode       (opcode),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .ctl          (ctl),
    .rd_slot      (rd_slot),
    .wr_slot      (wr_slot)
  );

  pcog_lane #(
    .WINDOW (WINDOW)
  ) u_lane_u (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_slot  (rd_slot),
    .wr_slot  (wr_slot),
    .code     (adc_code_u),
    .midpoint (adc_midpoint),
    .gain     (current_gain),
    .corr     (correction_u),
    .raw      (raw_u),
    .filt     (filt_u)
  );

  pcog_lane #(
    .WINDOW (WINDOW)
  ) u_lane_v (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_slot  (rd_slot),
    .wr_slot  (wr_slot),
    .code     (adc_code_v),
    .midpoint (adc_midpoint),
    .gain     (current_gain),
    .corr     (correction_v),
    .raw      (raw_v),
    .filt     (filt_v)
  );

  pcog_merge u_merge (
    .clk                    (clk),
    .rst                    (rst),
    .ctl                    (ctl),
    .raw_u                  (raw_u),
    .raw_v                  (raw_v),
    .filt_u                 (filt_u),
    .filt_v                 (filt_v),
    .instant_threshold      (instant_threshold),
    .continuous_threshold   (continuous_threshold),
    .instant_count_limit    (instant_count_limit),
    .continuous_count_limit (continuous_count_limit),
    .filtered_u             (filtered_u),
    .filtered_v             (filtered_v),
    .filtered_w             (filtered_w),
    .trip_latched           (trip_latched)
  );

endmodule

`default_nettype wire

@@ hdl/pcog_ctrl.sv @@
// pipeline occupancy, stage load strobes and ring slot pointer
`default_nettype none

module pcog_ctrl #(
  parameter int WINDOW = pcog_pkg::DEFAULT_WINDOW,
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              sample_valid,
  input  wire logic              opcode,
  output logic                   sample_stall,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output pcog_pkg::pipe_ctl_t    ctl,
  output logic [SLOT_W-1:0]      rd_slot,
  output logic [SLOT_W-1:0]      wr_slot
);

  localparam int N = pcog_pkg::NUM_STAGES;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic [N-1:0] vld;
  logic [N-1:0] free;
  logic [N-1:0] ld;
  logic [N-1:0] leave;
  logic [N-1:0] clr;
  logic [N-1:0] vld_next;

  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] slot0;
  logic [SLOT_W-1:0] slot1;

  // a stage can take an item when it is empty or its item moves on this cycle
  always_comb begin
    free[N-1] = !vld[N-1] || !result_stall;
    for (int k = N - 2; k >= 0; k--) begin
      free[k] = !vld[k] || free[k+1];
    end
    ld[0] = sample_valid && free[0];
    for (int k = 1; k < N; k++) begin
      ld[k] = vld[k-1] && free[k];
    end
    for (int k = 0; k < N - 1; k++) begin
      leave[k] = ld[k+1];
    end
    leave[N-1] = vld[N-1] && !result_stall;
    vld_next = ld | (vld & ~leave);
  end

  always_comb begin
    write_slot_next = (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      write_slot <= '0;
    end else begin
      vld <= vld_next;
      if (ld[pcog_pkg::ST_DIFF] && opcode == pcog_pkg::OP_SAMPLE) begin
        write_slot <= write_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[pcog_pkg::ST_DIFF]) begin
      clr[pcog_pkg::ST_DIFF] <= opcode;
      slot0                  <= write_slot;
    end
    if (ld[pcog_pkg::ST_MUL]) begin
      slot1 <= slot0;
    end
    for (int k = 1; k < N; k++) begin
      if (ld[k]) begin
        clr[k] <= clr[k-1];
      end
    end
  end

  assign ctl.ld       = ld;
  assign ctl.clr      = clr;
  assign sample_stall = !free[0];
  assign result_valid = vld[N-1];
  assign rd_slot      = slot0;
  assign wr_slot      = slot1;

endmodule

`default_nettype wire

@@ hdl/pcog_lane.sv @@
// one phase lane: adc scaling, sample ring, running sum and window average
`default_nettype none

module pcog_lane #(
  parameter int WINDOW = pcog_pkg::DEFAULT_WINDOW,
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire pcog_pkg::pipe_ctl_t               ctl,
  input  wire logic [SLOT_W-1:0]                 rd_slot,
  input  wire logic [SLOT_W-1:0]                 wr_slot,
  input  wire logic [pcog_pkg::CODE_W-1:0]       code,
  input  wire logic [pcog_pkg::CODE_W-1:0]       midpoint,
  input  wire logic [15:0]                       gain,
  input  wire logic signed [15:0]                corr,
  output logic signed [pcog_pkg::CUR_W-1:0]      raw,
  output logic signed [pcog_pkg::CUR_W-1:0]      filt
);

  localparam int CUR_W  = pcog_pkg::CUR_W;
  localparam int DIFF_W = pcog_pkg::CODE_W + 1;
  localparam int PROD_W = DIFF_W + 17;
  localparam int PRE_W  = PROD_W - 8 + 1;
  // sum is kept biased by WINDOW * 32768 so it never goes negative
  localparam int OFFSET = WINDOW * 32768;
  localparam int U_W    = $clog2(WINDOW * 65535 + 1);
  localparam int L_W    = $clog2(WINDOW);
  localparam int REC_K  = U_W + L_W;
  localparam int M_W    = U_W + 1;
  localparam int Q_W    = U_W + M_W;
  localparam logic [63:0] REC_M = ((64'd1 << REC_K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

  logic signed [DIFF_W-1:0] diff0;
  logic signed [PROD_W-1:0] prod1;
  logic signed [CUR_W-1:0]  old1_mem;
  logic                     old1_vld;
  logic signed [CUR_W-1:0]  old2;
  logic signed [PRE_W-1:0]  pre_sat;
  logic signed [CUR_W-1:0]  raw_next;
  logic signed [CUR_W-1:0]  ring [WINDOW];
  logic [WINDOW-1:0]        ring_vld;
  logic                     ring_we;
  logic                     bypass;
  logic [U_W-1:0]           sum_b;
  logic signed [U_W+1:0]    sum_wide;
  logic [U_W-1:0]           sum_next;
  logic [U_W-1:0]           snap3;
  logic [Q_W-1:0]           qprod4;
  logic [CUR_W-1:0]         quot;

  // scale, add correction, clamp to 16 bits
  always_comb begin
    pre_sat = PRE_W'($signed(prod1[PROD_W-1:8])) + PRE_W'(corr);
    if (pre_sat[PRE_W-1:CUR_W-1] == {(PRE_W - CUR_W + 1){pre_sat[PRE_W-1]}}) begin
      raw_next = pre_sat[CUR_W-1:0];
    end else begin
      raw_next = pre_sat[PRE_W-1] ? pcog_pkg::CUR_MIN : pcog_pkg::CUR_MAX;
    end
  end

  assign ring_we = ctl.ld[pcog_pkg::ST_RAW] && ctl.clr[pcog_pkg::ST_MUL] == pcog_pkg::OP_SAMPLE;
  // same slot read and written on one edge only happens with a one-deep window
  assign bypass  = ring_we && ctl.ld[pcog_pkg::ST_MUL] && (rd_slot == wr_slot);

  always_comb begin
    sum_wide = (U_W + 2)'($signed({1'b0, sum_b})) + (U_W + 2)'(raw) - (U_W + 2)'(old2);
    sum_next = sum_wide[U_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[wr_slot] <= raw_next;
    end
    if (ctl.ld[pcog_pkg::ST_MUL]) begin
      if (bypass) begin
        old1_mem <= raw_next;
      end else begin
        old1_mem <= ring[rd_slot];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_vld <= '0;
      sum_b    <= U_W'(OFFSET);
    end else begin
      if (ring_we) begin
        ring_vld[wr_slot] <= 1'b1;
      end
      if (ctl.ld[pcog_pkg::ST_SUM] && ctl.clr[pcog_pkg::ST_RAW] == pcog_pkg::OP_SAMPLE) begin
        sum_b <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[pcog_pkg::ST_DIFF]) begin
      diff0 <= $signed({1'b0, code}) - $signed({1'b0, midpoint});
    end
    if (ctl.ld[pcog_pkg::ST_MUL]) begin
      prod1    <= PROD_W'(diff0) * PROD_W'($signed({1'b0, gain}));
      old1_vld <= bypass || ring_vld[rd_slot];
    end
    if (ctl.ld[pcog_pkg::ST_RAW]) begin
      raw  <= raw_next;
      old2 <= old1_vld ? old1_mem : '0;
    end
    if (ctl.ld[pcog_pkg::ST_SUM]) begin
      snap3 <= (ctl.clr[pcog_pkg::ST_RAW] == pcog_pkg::OP_SAMPLE) ? sum_next : sum_b;
    end
    // floor divide by the window through a reciprocal multiply
    if (ctl.ld[pcog_pkg::ST_QMUL]) begin
      qprod4 <= Q_W'(snap3) * Q_W'(REC_M[M_W-1:0]);
    end
    if (ctl.ld[pcog_pkg::ST_FILT]) begin
      filt <= $signed({~quot[CUR_W-1], quot[CUR_W-2:0]});
    end
  end

  assign quot = qprod4[REC_K +: CUR_W];

endmodule

`default_nettype wire

@@ hdl/pcog_merge.sv @@
// combines both lanes: w phase, peak magnitudes, trip counters, latch and result register
`default_nettype none

module pcog_merge (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire pcog_pkg::pipe_ctl_t                 ctl,
  input  wire logic signed [pcog_pkg::CUR_W-1:0]   raw_u,
  input  wire logic signed [pcog_pkg::CUR_W-1:0]   raw_v,
  input  wire logic signed [pcog_pkg::CUR_W-1:0]   filt_u,
  input  wire logic signed [pcog_pkg::CUR_W-1:0]   filt_v,
  input  wire logic [15:0]                         instant_threshold,
  input  wire logic [15:0]                         continuous_threshold,
  input  wire logic [pcog_pkg::CNT_W-1:0]          instant_count_limit,
  input  wire logic [pcog_pkg::CNT_W-1:0]          continuous_count_limit,
  output logic signed [pcog_pkg::CUR_W-1:0]        filtered_u,
  output logic signed [pcog_pkg::CUR_W-1:0]        filtered_v,
  output logic signed [pcog_pkg::PHASE_W_W-1:0]    filtered_w,
  output logic                                     trip_latched
);

  localparam int CUR_W = pcog_pkg::CUR_W;
  localparam int WW    = pcog_pkg::PHASE_W_W;
  localparam int MAG_W = WW - 1;
  localparam int CNT_W = pcog_pkg::CNT_W;

  function automatic logic [MAG_W-1:0] mag(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] n;
    n = -x;
    return x[WW-1] ? n[MAG_W-1:0] : x[MAG_W-1:0];
  endfunction

  logic signed [WW-1:0]    raw_w;
  logic [MAG_W-1:0]        mag_u3;
  logic [MAG_W-1:0]        mag_v3;
  logic [MAG_W-1:0]        mag_w3;
  logic                    inst_ge4;
  logic                    inst_ge5;
  logic                    inst_ge6;
  logic                    inst_ge7;
  logic signed [CUR_W-1:0] fu6;
  logic signed [CUR_W-1:0] fv6;
  logic signed [WW-1:0]    fw6;
  logic signed [CUR_W-1:0] fu7;
  logic signed [CUR_W-1:0] fv7;
  logic signed [WW-1:0]    fw7;
  logic                    cont_ge7;
  logic [MAG_W-1:0]        inst_thr;
  logic [MAG_W-1:0]        cont_thr;

  logic [CNT_W-1:0] instant_count;
  logic [CNT_W-1:0] continuous_count;
  logic             trip_flag;
  logic [CNT_W-1:0] instant_count_next;
  logic [CNT_W-1:0] continuous_count_next;
  logic             trip_flag_next;

  assign raw_w    = -(WW'(raw_u) + WW'(raw_v));
  assign inst_thr = MAG_W'(instant_threshold);
  assign cont_thr = MAG_W'(continuous_threshold);

  always_ff @(posedge clk) begin
    if (ctl.ld[pcog_pkg::ST_SUM]) begin
      mag_u3 <= mag(WW'(raw_u));
      mag_v3 <= mag(WW'(raw_v));
      mag_w3 <= mag(raw_w);
    end
    // the largest magnitude reaches the threshold exactly when any one does
    if (ctl.ld[pcog_pkg::ST_QMUL]) begin
      inst_ge4 <= (mag_u3 >= inst_thr) || (mag_v3 >= inst_thr) || (mag_w3 >= inst_thr);
    end
    if (ctl.ld[pcog_pkg::ST_FILT]) begin
      inst_ge5 <= inst_ge4;
    end
    if (ctl.ld[pcog_pkg::ST_WPH]) begin
      inst_ge6 <= inst_ge5;
      fu6      <= filt_u;
      fv6      <= filt_v;
      fw6      <= -(WW'(filt_u) + WW'(filt_v));
    end
    if (ctl.ld[pcog_pkg::ST_CMP]) begin
      inst_ge7 <= inst_ge6;
      fu7      <= fu6;
      fv7      <= fv6;
      fw7      <= fw6;
      cont_ge7 <= (mag(WW'(fu6)) >= cont_thr) || (mag(WW'(fv6)) >= cont_thr) ||
                  (mag(fw6) >= cont_thr);
    end
    if (ctl.ld[pcog_pkg::ST_OUT]) begin
      filtered_u <= fu7;
      filtered_v <= fv7;
      filtered_w <= fw7;
    end
  end

  always_comb begin
    if (ctl.clr[pcog_pkg::ST_CMP] == pcog_pkg::OP_CLEAR) begin
      instant_count_next    = '0;
      continuous_count_next = '0;
      trip_flag_next        = 1'b0;
    end else begin
      if (inst_ge7) begin
        instant_count_next = (instant_count == pcog_pkg::CNT_MAX) ? instant_count
                                                                   : instant_count + 1'b1;
      end else begin
        instant_count_next = '0;
      end
      if (cont_ge7) begin
        continuous_count_next = (continuous_count == pcog_pkg::CNT_MAX) ? continuous_count
                                                                         : continuous_count + 1'b1;
      end else begin
        continuous_count_next = '0;
      end
      trip_flag_next = trip_flag || (instant_count_next >= instant_count_limit) ||
                       (continuous_count_next >= continuous_count_limit);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      instant_count    <= '0;
      continuous_count <= '0;
      trip_flag        <= 1'b0;
    end else if (ctl.ld[pcog_pkg::ST_OUT]) begin
      instant_count    <= instant_count_next;
      continuous_count <= continuous_count_next;
      trip_flag        <= trip_flag_next;
    end
  end

  assign trip_latched = trip_flag;

endmodule

`default_nettype wire

@@ hdl/pcog_checker.sv @@
// port-level checks for the phase current overcurrent guard and their bind
`default_nettype none

module pcog_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 sample_stall,
  input wire logic                                 result_valid,
  input wire logic                                 result_stall,
  input wire logic signed [pcog_pkg::CUR_W-1:0]    filtered_u,
  input wire logic signed [pcog_pkg::CUR_W-1:0]    filtered_v,
  input wire logic signed [pcog_pkg::PHASE_W_W-1:0] filtered_w,
  input wire logic                                 trip_latched
);

  localparam int WW = pcog_pkg::PHASE_W_W;

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(filtered_u) &&
      $stable(filtered_v) && $stable(filtered_w) && $stable(trip_latched))
    else $error("held result changed");

  // in every valid result the w phase mirrors the other two
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> filtered_w == -(WW'(filtered_u) + WW'(filtered_v)))
    else $error("filtered_w is not the negated sum of u and v");

  // the pipeline only pushes back when a result is waiting
  assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> !sample_stall)
    else $error("input stalled with no result pending");

  // the latch only sets together with a new result
  assert property (@(posedge clk) disable iff (rst)
    $rose(trip_latched) |-> result_valid)
    else $error("trip latch set without a result");

endmodule

bind phase_current_overcurrent_guard pcog_checker u_pcog_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .filtered_u   (filtered_u),
  .filtered_v   (filtered_v),
  .filtered_w   (filtered_w),
  .trip_latched (trip_latched)
);

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the phase current overcurrent guard
`timescale 1ns / 1ps

module tb_top;
  import pcog_pkg::*;

  localparam int WIN       = DEFAULT_WINDOW;
  localparam int WIN_SHIFT = $clog2(WIN);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'hF;

  typedef struct packed {
    logic signed [CUR_W-1:0]     fu;
    logic signed [CUR_W-1:0]     fv;
    logic signed [PHASE_W_W-1:0] fw;
    logic                        trip;
  } phase_result_t;

  typedef struct {
    logic              op;
    logic [CODE_W-1:0] cu;
    logic [CODE_W-1:0] cv;
    bit                pinned;
    phase_result_t     want;
  } stim_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        sample_valid = 1'b0;
  logic                        sample_stall;
  logic                        opcode = OP_SAMPLE;
  logic [CODE_W-1:0]           adc_code_u = '0;
  logic [CODE_W-1:0]           adc_code_v = '0;
  logic                        result_valid;
  logic                        result_stall = 1'b0;
  logic signed [CUR_W-1:0]     filtered_u;
  logic signed [CUR_W-1:0]     filtered_v;
  logic signed [PHASE_W_W-1:0] filtered_w;
  logic                        trip_latched;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  // sideband that travels with each item: a typed-in expectation
  bit            pin_row = 1'b0;
  phase_result_t pin_value = '0;

  // guard model: registers
  logic [CODE_W-1:0]       mid_cfg      = RST_ADC_MIDPOINT;
  logic [15:0]             gain_cfg     = RST_CURRENT_GAIN;
  logic signed [15:0]      corr_u_cfg   = RST_CORRECTION;
  logic signed [15:0]      corr_v_cfg   = RST_CORRECTION;
  logic [15:0]             inst_thr_cfg = RST_THRESHOLD;
  logic [15:0]             cont_thr_cfg = RST_THRESHOLD;
  logic [CNT_W-1:0]        inst_lim_cfg = RST_INSTANT_LIMIT;
  logic [CNT_W-1:0]        cont_lim_cfg = RST_CONTINUOUS_LIMIT;

  // guard model: filter and trip state
  logic signed [CUR_W-1:0] hist_u [WIN] = '{default: '0};
  logic signed [CUR_W-1:0] hist_v [WIN] = '{default: '0};
  int                      acc_u = 0;
  int                      acc_v = 0;
  int                      slot = 0;
  int                      inst_cnt = 0;
  int                      cont_cnt = 0;
  logic                    tripped = 1'b0;

  phase_result_t awaited_currents [$];
  int            items_taken = 0;
  int            results_taken = 0;
  int            mismatch_count = 0;
  int            hold_left = 0;
  bit            calm = 1'b0;

  stim_row_t directed_rows [14] = '{
    '{OP_SAMPLE, 12'd2048, 12'd2048, 1'b1, '{16'sd0, 16'sd0, 18'sd0, 1'b0}},
    '{OP_CLEAR,  12'd4095, 12'd0,    1'b1, '{16'sd0, 16'sd0, 18'sd0, 1'b0}},
    '{OP_SAMPLE, 12'd4095, 12'd0,    1'b1, '{16'sd255, -16'sd256, 18'sd1, 1'b0}},
    '{OP_SAMPLE, 12'd0,    12'd4095, 1'b0, '0},
    '{OP_SAMPLE, 12'd4095, 12'd4095, 1'b0, '0},
    '{OP_SAMPLE, 12'd0,    12'd0,    1'b0, '0},
    '{OP_SAMPLE, 12'h555,  12'hAAA,  1'b0, '0},
    '{OP_SAMPLE, 12'hAAA,  12'h555,  1'b0, '0},
    '{OP_CLEAR,  12'hFFF,  12'hFFF,  1'b0, '0},
    '{OP_SAMPLE, 12'd2047, 12'd2049, 1'b0, '0},
    '{OP_SAMPLE, 12'd1,    12'd4094, 1'b0, '0},
    '{OP_SAMPLE, 12'd2048, 12'd0,    1'b0, '0},
    '{OP_SAMPLE, 12'd4095, 12'd2048, 1'b0, '0},
    '{OP_CLEAR,  12'd0,    12'd0,    1'b0, '0}
  };

  phase_current_overcurrent_guard DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .opcode       (opcode),
    .adc_code_u   (adc_code_u),
    .adc_code_v   (adc_code_v),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .filtered_u   (filtered_u),
    .filtered_v   (filtered_v),
    .filtered_w   (filtered_w),
    .trip_latched (trip_latched),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("phase_current_overcurrent_guard regression: fail");
    $finish;
  end

  // adc code to q8.8 amperes, floor shift then clamp
  function automatic int to_current(logic [CODE_W-1:0] code, logic signed [15:0] corr);
    int prod;
    int v;
    prod = (int'(code) - int'(mid_cfg)) * int'(gain_cfg);
    v = (prod >>> 8) + int'(corr);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic int peak3(int a, int b, int c);
    int m;
    m = (a < 0) ? -a : a;
    if (b > m || -b > m) m = (b < 0) ? -b : b;
    if (c > m || -c > m) m = (c < 0) ? -c : c;
    return m;
  endfunction

  function automatic int bump(int cnt, int level, logic [15:0] thr);
    if (level >= int'(thr)) return (cnt < 255) ? cnt + 1 : 255;
    return 0;
  endfunction

  function automatic phase_result_t predict_guard(logic op, logic [CODE_W-1:0] cu,
                                                  logic [CODE_W-1:0] cv);
    phase_result_t r;
    int ru;
    int rv;
    int fu;
    int fv;
    if (op == OP_CLEAR) begin
      inst_cnt = 0;
      cont_cnt = 0;
      tripped  = 1'b0;
      fu = acc_u >>> WIN_SHIFT;
      fv = acc_v >>> WIN_SHIFT;
    end else begin
      ru = to_current(cu, corr_u_cfg);
      rv = to_current(cv, corr_v_cfg);
      acc_u += ru - int'(hist_u[slot]);
      acc_v += rv - int'(hist_v[slot]);
      hist_u[slot] = CUR_W'(ru);
      hist_v[slot] = CUR_W'(rv);
      slot = (slot + 1) % WIN;
      fu = acc_u >>> WIN_SHIFT;
      fv = acc_v >>> WIN_SHIFT;
      // |w| may reach 65536 and is compared at full width
      inst_cnt = bump(inst_cnt, peak3(ru, rv, -(ru + rv)), inst_thr_cfg);
      cont_cnt = bump(cont_cnt, peak3(fu, fv, -(fu + fv)), cont_thr_cfg);
      if (inst_cnt >= int'(inst_lim_cfg) || cont_cnt >= int'(cont_lim_cfg)) tripped = 1'b1;
    end
    r.fu   = CUR_W'(fu);
    r.fv   = CUR_W'(fv);
    r.fw   = PHASE_W_W'(-(fu + fv));
    r.trip = tripped;
    return r;
  endfunction

  function automatic int pick_idle();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_cfg(int ext_lo, int ext_hi, int lo, int hi);
    case ($urandom_range(0, 5))
      0: return ext_lo;
      1: return ext_hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic logic [CODE_W-1:0] draw_code();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return mid_cfg + CODE_W'($urandom_range(0, 128)) - 12'd64;
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("[%0t] mismatch on %s: got %0d, expected %0d (result %0d)",
             $time, what, got, want, results_taken);
  endtask

  task automatic send_item(input stim_row_t row);
    int gap;
    sample_valid <= 1'b1;
    opcode       <= row.op;
    adc_code_u   <= row.cu;
    adc_code_v   <= row.cv;
    pin_row      <= row.pinned;
    pin_value    <= row.want;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    items_taken++;
    gap = pick_idle();
    if (gap != 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle();
    sample_valid <= 1'b0;
    while (results_taken < items_taken) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic program_guard(input int mid, input int gain, input int cu, input int cv,
                               input int ithr, input int cthr, input int ilim, input int clim);
    write_reg(REG_ADC_MIDPOINT, {4'($urandom), CODE_W'(mid)});
    write_reg(REG_CURRENT_GAIN, 16'(gain));
    write_reg(REG_CORRECTION_U, 16'(cu));
    write_reg(REG_CORRECTION_V, 16'(cv));
    write_reg(REG_INSTANT_THRESHOLD, 16'(ithr));
    write_reg(REG_CONTINUOUS_THRESHOLD, 16'(cthr));
    write_reg(REG_INSTANT_COUNT_LIMIT, {8'($urandom), CNT_W'(ilim)});
    write_reg(REG_CONTINUOUS_COUNT_LIMIT, {8'($urandom), CNT_W'(clim)});
  endtask

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ADC_MIDPOINT:           mid_cfg      = cfg_data[CODE_W-1:0];
        REG_CURRENT_GAIN:           gain_cfg     = cfg_data;
        REG_CORRECTION_U:           corr_u_cfg   = cfg_data;
        REG_CORRECTION_V:           corr_v_cfg   = cfg_data;
        REG_INSTANT_THRESHOLD:      inst_thr_cfg = cfg_data;
        REG_CONTINUOUS_THRESHOLD:   cont_thr_cfg = cfg_data;
        REG_INSTANT_COUNT_LIMIT:    inst_lim_cfg = cfg_data[CNT_W-1:0];
        REG_CONTINUOUS_COUNT_LIMIT: cont_lim_cfg = cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin : predict_items
    phase_result_t r;
    if (!rst && sample_valid && !sample_stall) begin
      r = predict_guard(opcode, adc_code_u, adc_code_v);
      awaited_currents.push_back(pin_row ? pin_value : r);
    end
  end

  always @(posedge clk) begin : check_results
    phase_result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_taken++;
      if (awaited_currents.size() == 0) begin
        report_mismatch("item with none expected", int'(filtered_u), 0);
      end else begin
        want = awaited_currents.pop_front();
        if (filtered_u !== want.fu)
          report_mismatch("filtered_u", int'(filtered_u), int'(want.fu));
        if (filtered_v !== want.fv)
          report_mismatch("filtered_v", int'(filtered_v), int'(want.fv));
        if (filtered_w !== want.fw)
          report_mismatch("filtered_w", int'(filtered_w), int'(want.fw));
        if (trip_latched !== want.trip)
          report_mismatch("trip_latched", int'(trip_latched), int'(want.trip));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || calm) begin
      hold_left = 0;
      result_stall <= 1'b0;
    end else begin
      if (hold_left == 0 && $urandom_range(0, 3) == 0) hold_left = pick_idle();
      result_stall <= (hold_left != 0);
      if (hold_left != 0) hold_left--;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset register values, directed codes
    foreach (directed_rows[i]) send_item(directed_rows[i]);
    settle();

    // full-scale negative on both phases: raw and filtered saturate, |w| hits 65536
    program_guard(4095, 65535, -32768, -32768, 65535, 65535, 255, 3);
    write_reg(REG_UNUSED, 16'h0000);
    row = '{OP_SAMPLE, 12'd0, 12'd0, 1'b0, '0};
    repeat (11) send_item(row);
    row.op = OP_CLEAR;
    send_item(row);
    row = '{OP_SAMPLE, 12'd4095, 12'd4095, 1'b0, '0};
    repeat (2) send_item(row);
    settle();

    // zero count limits trip on every sample
    program_guard(2048, 256, 0, 0, 65535, 65535, 0, 0);
    row = '{OP_SAMPLE, 12'd2048, 12'd2048, 1'b0, '0};
    send_item(row);
    row.op = OP_CLEAR;
    send_item(row);
    row.op = OP_SAMPLE;
    send_item(row);
    settle();

    // long overcurrent run drives both counters to 255, then quiet samples drop them
    program_guard(2048, 256, 0, 0, 1000, 1000, 255, 255);
    row = '{OP_SAMPLE, 12'd0, 12'd0, 1'b0, '0};
    repeat (270) begin
      row.cu = CODE_W'($urandom_range(0, 500));
      row.cv = CODE_W'($urandom);
      send_item(row);
    end
    repeat (14) begin
      row.cu = CODE_W'($urandom_range(1948, 2148));
      row.cv = CODE_W'($urandom_range(1948, 2148));
      send_item(row);
    end
    settle();

    for (int p = 0; p < 7; p++) begin
      calm = (p % 3 == 1);
      program_guard(pick_cfg(0, 4095, 1536, 2560), pick_cfg(0, 65535, 1, 1024),
                    pick_cfg(-32768, 32767, -512, 511), pick_cfg(-32768, 32767, -512, 511),
                    pick_cfg(0, 65535, 0, 4000), pick_cfg(0, 65535, 0, 4000),
                    pick_cfg(0, 255, 1, 8), pick_cfg(0, 255, 1, 8));
      repeat (80) begin
        row.op = ($urandom_range(0, 99) < 4) ? OP_CLEAR : OP_SAMPLE;
        row.cu = draw_code();
        row.cv = draw_code();
        row.pinned = 1'b0;
        send_item(row);
        if ($urandom_range(0, 99) == 0) settle();
      end
      settle();
    end
    calm = 1'b0;

    repeat (40) @(posedge clk);
    if (awaited_currents.size() != 0)
      report_mismatch("items never returned", 0, awaited_currents.size());
    if (mismatch_count == 0) begin
      $display("phase_current_overcurrent_guard regression: pass");
    end else begin
      $display("phase_current_overcurrent_guard regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pcog_pkg.sv
hdl/pcog_ctrl.sv
hdl/pcog_lane.sv
hdl/pcog_merge.sv
hdl/phase_current_overcurrent_guard.sv
hdl/pcog_checker.sv
tb/tb_top.sv
